/* rtl/core/pidsc_pkg.sv */
// Package with the word types and command codes of the packet statistics counters.
`default_nettype none
package pidsc_pkg;

  localparam int CNT_W       = 64;
  localparam int ID_FIELD_W  = 8;
  localparam int LEN_FIELD_W = 16;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = ID_FIELD_W + 1;

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic                   dir;
    logic [ID_FIELD_W-1:0]  type_id;
    logic [ID_FIELD_W-1:0]  last_id;
    logic [LEN_FIELD_W-1:0] pkt_length;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] pkt_count;
    logic [CNT_W-1:0] byte_count;
    logic [CNT_W-1:0] total_pkts;
    logic [CNT_W-1:0] total_bytes;
  } out_word_t;

  // One table row: the packet and byte counters of one id in one direction.
  typedef struct packed {
    logic [CNT_W-1:0] pkts;
    logic [CNT_W-1:0] octets;
  } cnt_row_t;

  localparam int ROW_W = 2 * CNT_W;

endpackage
`default_nettype wire

/* rtl/core/pidsc_in_if.sv */
// Command channel interface: valid, ready and one command word.
`default_nettype none
interface pidsc_in_if;
  import pidsc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/pidsc_out_if.sv */
// Result channel interface: valid, ready and one result word.
`default_nettype none
interface pidsc_out_if;
  import pidsc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/pidsc_ram.sv */
// Simple dual-port counter RAM with one write port and one registered read port.
`default_nettype none
module pidsc_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 128
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/core/pidsc_ctrl.sv */
// Command sequencer: table clear, read-modify-write of counters, range walk and totals.
`default_nettype none
module pidsc_ctrl #(
  parameter int NUM_IDS  = 256,
  parameter int LEN_BITS = 16,
  localparam int ID_W    = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1,
  localparam int ADDR_W  = ID_W + 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  pidsc_in_if.sink                in_chan,
  pidsc_out_if.source             out_chan,
  output logic                    ram_we,
  output logic [ADDR_W-1:0]       ram_waddr,
  output pidsc_pkg::cnt_row_t     ram_wdata,
  output logic                    ram_re,
  output logic [ADDR_W-1:0]       ram_raddr,
  input  wire pidsc_pkg::cnt_row_t ram_rdata
);
  import pidsc_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_RSUM   = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  localparam logic [ID_FIELD_W-1:0] ID_MAX = ID_FIELD_W'(NUM_IDS - 1);
  localparam int LEN_KEEP = (LEN_BITS < LEN_FIELD_W) ? LEN_BITS : LEN_FIELD_W;
  localparam logic [LEN_FIELD_W-1:0] LEN_MASK =
    LEN_FIELD_W'((33'd1 << LEN_KEEP) - 33'd1);

  // Control state.
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  tot_pkt_r [2];
  logic [CNT_W-1:0]  tot_pkt_nxt [2];
  logic [CNT_W-1:0]  tot_byte_r [2];
  logic [CNT_W-1:0]  tot_byte_nxt [2];

  // Payload state of the word at work.
  logic [CMD_W-1:0]       cmd_r, cmd_nxt;
  logic                   dir_r, dir_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic                   hit_r, hit_nxt;
  logic [LEN_FIELD_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [ID_FIELD_W-1:0]  end_r, end_nxt;
  logic [CNT_W-1:0]       acc_pkt_r, acc_pkt_nxt;
  logic [CNT_W-1:0]       acc_byte_r, acc_byte_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic             rd_more;
  logic             slot_free;
  logic [CNT_W-1:0] rec_pkts;
  logic [CNT_W-1:0] rec_octets;

  assign rd_more    = (idx_r <= {1'b0, end_r});
  assign slot_free  = !out_valid_r || out_chan.ready;
  assign rec_pkts   = ram_rdata.pkts + CNT_W'(1);
  assign rec_octets = ram_rdata.octets + CNT_W'(len_r);

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    tot_pkt_nxt   = tot_pkt_r;
    tot_byte_nxt  = tot_byte_r;
    cmd_nxt       = cmd_r;
    dir_nxt       = dir_r;
    id_nxt        = id_r;
    hit_nxt       = hit_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    acc_pkt_nxt   = acc_pkt_r;
    acc_byte_nxt  = acc_byte_r;
    out_data_nxt  = out_data_r;

    ram_we    = 1'b0;
    ram_waddr = {dir_r, id_r};
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {in_chan.data.dir, in_chan.data.type_id[ID_W-1:0]};

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          ram_re       = 1'b1;
          cmd_nxt      = in_chan.data.cmd;
          dir_nxt      = in_chan.data.dir;
          id_nxt       = in_chan.data.type_id[ID_W-1:0];
          hit_nxt      = (in_chan.data.type_id <= ID_MAX);
          len_nxt      = in_chan.data.pkt_length & LEN_MASK;
          idx_nxt      = {1'b0, in_chan.data.type_id};
          end_nxt      = (in_chan.data.last_id > ID_MAX) ? ID_MAX : in_chan.data.last_id;
          pend_nxt     = 1'b0;
          acc_pkt_nxt  = '0;
          acc_byte_nxt = '0;
          case (in_chan.data.cmd)
            CMD_RECORD: state_nxt = ST_UPDATE;
            CMD_READ:   state_nxt = ST_UPDATE;
            CMD_RANGE:  state_nxt = ST_RSUM;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_UPDATE: begin
        // The row read at accept is in ram_rdata now.
        if (cmd_r == CMD_RECORD) begin
          tot_pkt_nxt[dir_r]  = tot_pkt_r[dir_r] + CNT_W'(1);
          tot_byte_nxt[dir_r] = tot_byte_r[dir_r] + CNT_W'(len_r);
          if (hit_r) begin
            ram_we           = 1'b1;
            ram_wdata.pkts   = rec_pkts;
            ram_wdata.octets = rec_octets;
            acc_pkt_nxt      = rec_pkts;
            acc_byte_nxt     = rec_octets;
          end
        end else if (hit_r) begin
          acc_pkt_nxt  = ram_rdata.pkts;
          acc_byte_nxt = ram_rdata.octets;
        end
        state_nxt = ST_FIN;
      end
      ST_RSUM: begin
        // One read is issued per cycle while ids remain; its row is added in the next cycle.
        ram_raddr = {dir_r, idx_r[ID_W-1:0]};
        ram_re    = rd_more;
        pend_nxt  = rd_more;
        if (rd_more) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
        if (pend_r) begin
          acc_pkt_nxt  = acc_pkt_r + ram_rdata.pkts;
          acc_byte_nxt = acc_byte_r + ram_rdata.octets;
        end
        if (!rd_more && !pend_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.pkt_count   = acc_pkt_r;
          out_data_nxt.byte_count  = acc_byte_r;
          out_data_nxt.total_pkts  = tot_pkt_r[dir_r];
          out_data_nxt.total_bytes = tot_byte_r[dir_r];
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      tot_pkt_r[0]  <= '0;
      tot_pkt_r[1]  <= '0;
      tot_byte_r[0] <= '0;
      tot_byte_r[1] <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
      tot_pkt_r     <= tot_pkt_nxt;
      tot_byte_r    <= tot_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    dir_r      <= dir_nxt;
    id_r       <= id_nxt;
    hit_r      <= hit_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    acc_pkt_r  <= acc_pkt_nxt;
    acc_byte_r <= acc_byte_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/packet_id_statistics_counters.sv */
// Top level of the per-type packet and byte statistics counters.
`default_nettype none
// Packet and byte counters per type id and direction, with a running total per
// direction. The counters live in one RAM row per {direction, id}. After reset
// the block clears every row of that RAM, one row a cycle, and accepts no
// command word meanwhile. A record or a read goes through the accept, which
// issues the row read of the RAM, the add and write-back of a record, and the
// load of the output register. A range sum walks the ids of the clamped range
// with one RAM read per id before that load. The load of the output register
// waits while the previous result word still sits there unaccepted. A finished
// result waits in the output register while the next command word is accepted
// and worked on.
module packet_id_statistics_counters #(
  parameter int NUM_IDS  = 256,
  parameter int LEN_BITS = 16
) (
  input wire logic     clk,
  input wire logic     rst_n,
  pidsc_in_if.sink     in_chan,
  pidsc_out_if.source  out_chan
);
  import pidsc_pkg::*;

  localparam int ID_W   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int ADDR_W = ID_W + 1;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cnt_row_t          ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  cnt_row_t          ram_rdata;

  pidsc_ctrl #(
    .NUM_IDS  (NUM_IDS),
    .LEN_BITS (LEN_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  pidsc_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

/* sim/packet_id_statistics_counters_test.sv */
// Self-checking testbench for the per-type packet and byte statistics counters.
`timescale 1ns / 100ps
module packet_id_statistics_counters_test;
  import pidsc_pkg::*;

  localparam int NUM_IDS = 256;
  localparam int LEN_BITS = 16;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [CNT_W-1:0] LEN_MASK = (64'd1 << LEN_BITS) - 64'd1;
  localparam int RANDOM_WORDS = 1880;
  localparam int CALM_TAIL = 300;
  localparam int DRAIN_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;

  pidsc_in_if in_chan ();
  pidsc_out_if out_chan ();

  packet_id_statistics_counters #(
    .NUM_IDS(NUM_IDS),
    .LEN_BITS(LEN_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  // Our own copy of the counters, indexed by direction then id.
  logic [CNT_W-1:0] pkt_tally[2][NUM_IDS] = '{default: '0};
  logic [CNT_W-1:0] byte_tally[2][NUM_IDS] = '{default: '0};
  logic [CNT_W-1:0] pkt_sum[2] = '{default: '0};
  logic [CNT_W-1:0] byte_sum[2] = '{default: '0};

  in_word_t cmd_words[$];
  out_word_t expected_counts[$];
  out_word_t want;
  int send_gap;
  int recv_hold;
  int quiet_cycles;
  int fail_count;

  // Applies one command word to the counter copy and returns the result word.
  function automatic out_word_t tally_word(input in_word_t w);
    out_word_t r;
    logic [CNT_W-1:0] len;
    int d;
    int hi;
    len = {48'd0, w.pkt_length} & LEN_MASK;
    d = w.dir;
    r = '0;
    case (w.cmd)
      CMD_RECORD: begin
        pkt_sum[d] = pkt_sum[d] + 64'd1;
        byte_sum[d] = byte_sum[d] + len;
        if (w.type_id < NUM_IDS) begin
          pkt_tally[d][w.type_id] = pkt_tally[d][w.type_id] + 64'd1;
          byte_tally[d][w.type_id] = byte_tally[d][w.type_id] + len;
          r.pkt_count = pkt_tally[d][w.type_id];
          r.byte_count = byte_tally[d][w.type_id];
        end
      end
      CMD_READ: begin
        if (w.type_id < NUM_IDS) begin
          r.pkt_count = pkt_tally[d][w.type_id];
          r.byte_count = byte_tally[d][w.type_id];
        end
      end
      CMD_RANGE: begin
        hi = (w.last_id > NUM_IDS - 1) ? NUM_IDS - 1 : w.last_id;
        for (int i = w.type_id; i <= hi; i++) begin
          r.pkt_count = r.pkt_count + pkt_tally[d][i];
          r.byte_count = r.byte_count + byte_tally[d][i];
        end
      end
      default: begin
      end
    endcase
    r.total_pkts = pkt_sum[d];
    r.total_bytes = byte_sum[d];
    return r;
  endfunction

  function automatic in_word_t pack_word(input logic [CMD_W-1:0] cmd, input logic dir,
                                         input logic [7:0] first, input logic [7:0] last,
                                         input logic [15:0] len);
    in_word_t w;
    w.cmd = cmd;
    w.dir = dir;
    w.type_id = first;
    w.last_id = last;
    w.pkt_length = len;
    return w;
  endfunction

  function automatic logic [15:0] pick_length();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hffff;
    if (roll < 5) return 16'($urandom_range(40, 1500));
    return 16'($urandom);
  endfunction

  // Ids for records, reads and range starts are steered toward a few busy ids so that their counts grow.
  function automatic logic [7:0] pick_id();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 8'($urandom_range(0, 7));
    if (roll == 4) return 8'($urandom_range(248, 255));
    return 8'($urandom);
  endfunction

  function automatic in_word_t random_word();
    int roll;
    int lo;
    int hi;
    logic dir;
    roll = $urandom_range(0, 99);
    dir = 1'($urandom);
    if (roll < 55)
      return pack_word(CMD_RECORD, dir, pick_id(), 8'($urandom), pick_length());
    if (roll < 75)
      return pack_word(CMD_READ, dir, pick_id(), 8'($urandom), 16'($urandom));
    if (roll < 95) begin
      roll = $urandom_range(0, 19);
      lo = pick_id();
      if (roll < 16) begin
        hi = lo + $urandom_range(0, 6);
        if (hi > 255) hi = 255;
      end else if (roll < 18) begin
        hi = $urandom_range(0, 255);
      end else if (roll == 18) begin
        lo = 0;
        hi = 255;
      end else begin
        // Start past the end: the sum must come back as zero.
        lo = $urandom_range(1, 255);
        hi = $urandom_range(0, lo - 1);
      end
      return pack_word(CMD_RANGE, dir, 8'(lo), 8'(hi), 16'($urandom));
    end
    return pack_word(CMD_SPARE, dir, 8'($urandom), 8'($urandom), 16'($urandom));
  endfunction

  // Idling comes and goes in long stretches and stops for the last part of the run.
  function automatic bit idling_allowed();
    return cmd_words.size() >= CALM_TAIL && (cmd_words.size() / 150) % 3 != 0;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                             input logic [CNT_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;

    // Directed opening: extreme ids and lengths, every command, empty ranges.
    cmd_words.push_back(pack_word(CMD_READ, 1'b0, 8'd0, 8'd0, 16'd0));
    cmd_words.push_back(pack_word(CMD_RECORD, 1'b0, 8'd0, 8'd0, 16'd0));
    cmd_words.push_back(pack_word(CMD_RECORD, 1'b0, 8'd0, 8'd255, 16'hffff));
    cmd_words.push_back(pack_word(CMD_RECORD, 1'b1, 8'd255, 8'd0, 16'hffff));
    cmd_words.push_back(pack_word(CMD_RECORD, 1'b1, 8'd255, 8'd255, 16'd1));
    cmd_words.push_back(pack_word(CMD_RECORD, 1'b0, 8'd255, 8'd17, 16'd12345));
    cmd_words.push_back(pack_word(CMD_RECORD, 1'b1, 8'd128, 8'd64, 16'h8000));
    cmd_words.push_back(pack_word(CMD_READ, 1'b0, 8'd0, 8'd255, 16'hffff));
    cmd_words.push_back(pack_word(CMD_READ, 1'b1, 8'd255, 8'd0, 16'd0));
    cmd_words.push_back(pack_word(CMD_READ, 1'b1, 8'd0, 8'd0, 16'd0));
    cmd_words.push_back(pack_word(CMD_RANGE, 1'b0, 8'd0, 8'd255, 16'd0));
    cmd_words.push_back(pack_word(CMD_RANGE, 1'b1, 8'd0, 8'd255, 16'hffff));
    cmd_words.push_back(pack_word(CMD_RANGE, 1'b0, 8'd255, 8'd255, 16'd0));
    cmd_words.push_back(pack_word(CMD_RANGE, 1'b0, 8'd255, 8'd0, 16'd0));
    cmd_words.push_back(pack_word(CMD_RANGE, 1'b1, 8'd1, 8'd0, 16'd0));
    cmd_words.push_back(pack_word(CMD_RANGE, 1'b0, 8'd0, 8'd0, 16'd0));
    cmd_words.push_back(pack_word(CMD_RANGE, 1'b1, 8'd100, 8'd200, 16'd0));
    cmd_words.push_back(pack_word(CMD_SPARE, 1'b0, 8'd17, 8'd200, 16'd999));
    cmd_words.push_back(pack_word(CMD_SPARE, 1'b1, 8'd255, 8'd255, 16'hffff));
    cmd_words.push_back(pack_word(CMD_READ, 1'b1, 8'd128, 8'd0, 16'd0));
    for (int n = 0; n < RANDOM_WORDS; n++)
      cmd_words.push_back(random_word());

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (cmd_words.size() != 0 || in_chan.valid || expected_counts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Command side: offers the next word, holds it until taken, idles in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.data <= '0;
      send_gap <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        expected_counts.push_back(tally_word(in_chan.data));
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_chan.valid <= 1'b0;
        end else if (cmd_words.size() != 0 && idling_allowed() &&
                     $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 13);
          in_chan.valid <= 1'b0;
        end else if (cmd_words.size() != 0) begin
          in_chan.valid <= 1'b1;
          in_chan.data <= cmd_words.pop_front();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each word taken against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_counts.size() == 0) begin
          $error("result word with no command outstanding: %p", out_chan.data);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          check_field("pkt_count", want.pkt_count, out_chan.data.pkt_count);
          check_field("byte_count", want.byte_count, out_chan.data.byte_count);
          check_field("total_pkts", want.total_pkts, out_chan.data.total_pkts);
          check_field("total_bytes", want.total_bytes, out_chan.data.total_bytes);
        end
      end
      if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        out_chan.ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        recv_hold <= $urandom_range(0, 13);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
